// ===== sv/lfra_pkg.sv =====
// package: sizes, state encoding and shared types of the lowest free room allocator
`timescale 1ns / 1ps

package lfra_pkg;

  localparam int unsigned ROOMS     = 64;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned ROOM_W    = 7;
  localparam int unsigned IDX_W     = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int unsigned CNT_W     = $clog2(ROOMS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } lfra_state_e;

  typedef struct packed {
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [TIME_BITS-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [ROOM_W-1:0] room_number;
    logic              all_busy;
    logic [ROOM_W-1:0] max_room_used;
  } result_t;

  function automatic logic [ROOM_W-1:0] fit_room(input logic [CNT_W-1:0] val);
    logic [CNT_W+ROOM_W-1:0] wide;
    wide = {{ROOM_W{1'b0}}, val};
    return wide[ROOM_W-1:0];
  endfunction

endpackage

// ===== sv/lowest_free_room_allocator.sv =====
// top level of the lowest free room allocator
// Booking requests (arrival_time_i, departure_time_i) enter on the input channel,
// in nondecreasing arrival order; each yields one result transaction with the
// assigned 1-based room, an all-busy flag and the highest room used so far.
// Rooms in use always form a prefix, so only rooms 1..max_room_used are scanned.
// The scan reads one stored release time per cycle from the release time memory
// (one registered read port); one request is worked on at a time and in_stall_o is
// high from acceptance until the result is written to the output register, so the
// next request can be taken in the cycle after that write.
// The output register holds one result; a new request is taken while it waits.
// If out_stall_i holds the register full, the finished result waits inside and
// neither memory nor room count is updated until it can be passed on.
// Reset clears the room count and all control state; no clearing pass is needed,
// since memory entries are only read after they have been written.
`timescale 1ns / 1ps

module lowest_free_room_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lfra_pkg::TIME_BITS-1:0] arrival_time_i,
  input  logic [lfra_pkg::TIME_BITS-1:0] departure_time_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lfra_pkg::ROOM_W-1:0]    room_number_o,
  output logic                           all_busy_o,
  output logic [lfra_pkg::ROOM_W-1:0]    max_room_used_o
);

  lfra_pkg::mem_req_t             mem_req;
  logic [lfra_pkg::TIME_BITS-1:0] rd_data;
  logic                           push;
  logic                           push_rdy;
  lfra_pkg::result_t              result;

  lfra_time_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  lfra_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .arrival_time_i   (arrival_time_i),
    .departure_time_i (departure_time_i),
    .mem_req_o        (mem_req),
    .rd_data_i        (rd_data),
    .push_o           (push),
    .result_o         (result),
    .push_rdy_i       (push_rdy)
  );

  lfra_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .result_i        (result),
    .push_rdy_o      (push_rdy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .room_number_o   (room_number_o),
    .all_busy_o      (all_busy_o),
    .max_room_used_o (max_room_used_o)
  );

endmodule

// ===== sv/lfra_time_mem.sv =====
// release time memory: one write port, one registered read port
`timescale 1ns / 1ps

module lfra_time_mem (
  input  logic                           clk_i,
  input  lfra_pkg::mem_req_t             req_i,
  output logic [lfra_pkg::TIME_BITS-1:0] rd_data_o
);

  logic [lfra_pkg::TIME_BITS-1:0] mem_q [lfra_pkg::ROOMS];
  logic [lfra_pkg::TIME_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/lfra_ctrl.sv =====
// scan sequencer: walks the used rooms, picks the lowest free one and writes it back
`timescale 1ns / 1ps

module lfra_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lfra_pkg::TIME_BITS-1:0] arrival_time_i,
  input  logic [lfra_pkg::TIME_BITS-1:0] departure_time_i,
  output lfra_pkg::mem_req_t             mem_req_o,
  input  logic [lfra_pkg::TIME_BITS-1:0] rd_data_i,
  output logic                           push_o,
  output lfra_pkg::result_t              result_o,
  input  logic                           push_rdy_i
);

  lfra_pkg::lfra_state_e state_q, state_d;

  logic [lfra_pkg::TIME_BITS-1:0] arr_q, arr_d;
  logic [lfra_pkg::TIME_BITS-1:0] dep_q, dep_d;
  logic [lfra_pkg::CNT_W-1:0]     adr_q, adr_d;
  logic [lfra_pkg::CNT_W-1:0]     hi_q, hi_d;
  logic [lfra_pkg::CNT_W-1:0]     slot_q, slot_d;
  logic                           rd_vld_q, rd_vld_d;
  logic                           busy_q, busy_d;

  logic                       accept;
  logic                       hit;
  logic                       scan_end;
  logic                       issue;
  logic                       commit;
  logic [lfra_pkg::CNT_W-1:0] slot_inc;
  logic [lfra_pkg::CNT_W-1:0] hi_nxt;

  assign accept   = in_valid_i && !in_stall_o;
  assign hit      = rd_vld_q && (rd_data_i < arr_q);
  assign scan_end = !hit && (adr_q == hi_q);
  assign issue    = (state_q == lfra_pkg::ST_SCAN) && !hit && !scan_end;
  assign commit   = (state_q == lfra_pkg::ST_DONE) && push_rdy_i;
  assign slot_inc = slot_q + lfra_pkg::CNT_W'(1);
  assign hi_nxt   = (!busy_q && (slot_inc > hi_q)) ? slot_inc : hi_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lfra_pkg::ST_IDLE: begin
        if (accept) state_d = lfra_pkg::ST_SCAN;
      end
      lfra_pkg::ST_SCAN: begin
        if (hit || scan_end) state_d = lfra_pkg::ST_DONE;
      end
      lfra_pkg::ST_DONE: begin
        if (push_rdy_i) state_d = lfra_pkg::ST_IDLE;
      end
      default: state_d = lfra_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o        = (state_q != lfra_pkg::ST_IDLE);
    mem_req_o.rd_en   = issue;
    mem_req_o.rd_addr = adr_q[lfra_pkg::IDX_W-1:0];
    mem_req_o.wr_en   = commit && !busy_q;
    mem_req_o.wr_addr = slot_q[lfra_pkg::IDX_W-1:0];
    mem_req_o.wr_data = dep_q;
    push_o            = commit;
    result_o.room_number   = busy_q ? '0 : lfra_pkg::fit_room(slot_inc);
    result_o.all_busy      = busy_q;
    result_o.max_room_used = lfra_pkg::fit_room(hi_nxt);
  end

  // datapath
  always_comb begin
    arr_d    = accept ? arrival_time_i : arr_q;
    dep_d    = accept ? departure_time_i : dep_q;
    adr_d    = adr_q;
    rd_vld_d = issue;
    slot_d   = slot_q;
    busy_d   = busy_q;
    hi_d     = commit ? hi_nxt : hi_q;
    if (accept) begin
      adr_d = '0;
    end else if (issue) begin
      adr_d = adr_q + lfra_pkg::CNT_W'(1);
    end
    if (state_q == lfra_pkg::ST_SCAN) begin
      priority if (hit) begin
        slot_d = adr_q - lfra_pkg::CNT_W'(1);
        busy_d = 1'b0;
      end else if (scan_end) begin
        slot_d = hi_q;
        busy_d = (hi_q == lfra_pkg::CNT_W'(lfra_pkg::ROOMS));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lfra_pkg::ST_IDLE;
      adr_q    <= '0;
      hi_q     <= '0;
      rd_vld_q <= 1'b0;
      busy_q   <= 1'b0;
      slot_q   <= '0;
    end else begin
      state_q  <= state_d;
      adr_q    <= adr_d;
      hi_q     <= hi_d;
      rd_vld_q <= rd_vld_d;
      busy_q   <= busy_d;
      slot_q   <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arr_q <= arr_d;
    dep_q <= dep_d;
  end

`ifndef NO_ASSERTIONS
  a_hi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_q <= lfra_pkg::CNT_W'(lfra_pkg::ROOMS))
    else $error("room fill count beyond room total");

  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lfra_pkg::ST_DONE && busy_q) |-> hi_q == lfra_pkg::CNT_W'(lfra_pkg::ROOMS))
    else $error("all busy flagged with a never used room left");

  a_slot_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lfra_pkg::ST_DONE && !busy_q) |-> slot_q <= hi_q)
    else $error("chosen room beyond the used prefix");

  a_adr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lfra_pkg::ST_SCAN) |-> adr_q <= hi_q)
    else $error("scan address beyond the used prefix");

  a_hi_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (hi_q == $past(hi_q)) || (hi_q == $past(hi_q) + lfra_pkg::CNT_W'(1)))
    else $error("fill count moved by more than one room");
`endif

endmodule

// ===== sv/lfra_out_reg.sv =====
// output register holding one result transaction
`timescale 1ns / 1ps

module lfra_out_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  lfra_pkg::result_t           result_i,
  output logic                        push_rdy_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lfra_pkg::ROOM_W-1:0] room_number_o,
  output logic                        all_busy_o,
  output logic [lfra_pkg::ROOM_W-1:0] max_room_used_o
);

  logic              valid_q, valid_d;
  lfra_pkg::result_t data_q, data_d;

  assign push_rdy_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (push_i && push_rdy_o) begin
      valid_d = 1'b1;
      data_d  = result_i;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o     = valid_q;
  assign room_number_o   = data_q.room_number;
  assign all_busy_o      = data_q.all_busy;
  assign max_room_used_o = data_q.max_room_used;

endmodule
